### hw/rtl/t2ss_pkg.sv
package t2ss_pkg;

    // Active-low segment codes: bit 7 = a ... bit 1 = g, bit 0 = dot
    localparam logic [7:0] SEG_BLANK    = 8'hFF;
    localparam logic [7:0] SEG_MINUS    = 8'hFD;
    localparam logic [7:0] SEG_DOT_MASK = 8'hFE;

    // Largest whole-degree value that fits three digits
    localparam logic [11:0] MAX_WHOLE = 12'd999;

    // Reciprocal constants for the digit split
    localparam logic [15:0] RECIP_100 = 16'd41;   // x/100 = (x*41)>>12 for x < 1000
    localparam logic [14:0] RECIP_10  = 15'd205;  // x/10  = (x*205)>>11 for x < 1029

    typedef logic [7:0] t_seg;

    // Decimal digit to segment code
    function automatic t_seg seg_code(input logic [3:0] digit);
        t_seg code;
        case (digit)
            4'd0: code = 8'b00000011;
            4'd1: code = 8'b10011111;
            4'd2: code = 8'b00100101;
            4'd3: code = 8'b00001101;
            4'd4: code = 8'b10011001;
            4'd5: code = 8'b01001001;
            4'd6: code = 8'b01000001;
            4'd7: code = 8'b00011111;
            4'd8: code = 8'b00000001;
            4'd9: code = 8'b00001001;
            default: code = SEG_BLANK;
        endcase
        return code;
    endfunction

endpackage

### hw/rtl/temperature_to_seven_segment_top.sv
// Temperature to seven-segment converter.
// Input channel: i_valid / o_stall with i_temp_raw, a signed reading in
// 1/16 degree steps. A transaction is taken at a clock edge with i_valid high
// and o_stall low.
// Output channel: o_valid / i_stall with four active-low segment codes
// (hundreds, tens, ones with dot lit, tenths) and o_range_error, set with all
// digits blank when the whole-degree magnitude is above 999.
// The accepted reading passes through the input register and then the result
// register before it reaches the outputs.
// Throughput: one transaction per cycle while i_stall is low; the input
// register feeds the digit split (two reciprocal multiplies and a table lookup),
// which is combinational, into the result register.
// When the receiver stalls, the result register holds, and one more
// transaction is still taken into the input register; o_stall rises only
// when both registers are full and i_stall is high.
// Reset (synchronous, active low) empties both stages; the data registers are not reset.
module temperature_to_seven_segment_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [15:0] i_temp_raw,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_digit_hundreds,
    output logic [7:0]  o_digit_tens,
    output logic [7:0]  o_digit_ones,
    output logic [7:0]  o_digit_tenths,
    output logic        o_range_error
);

    logic        r_s1_valid;
    logic [15:0] r_s1_raw;
    logic        r_out_valid;
    logic [7:0]  r_hund;
    logic [7:0]  r_tens;
    logic [7:0]  r_ones;
    logic [7:0]  r_tenths;
    logic        r_err;

    logic        out_move;
    logic        s1_move;

    logic        neg;
    logic [15:0] mag;
    logic [11:0] whole;
    logic [9:0]  whole10;
    logic [3:0]  frac;
    logic [15:0] hund_prod;
    logic [3:0]  hund;
    logic [9:0]  rem_full;
    logic [6:0]  rem;
    logic [14:0] tens_prod;
    logic [3:0]  tens;
    logic [6:0]  ones_full;
    logic [7:0]  frac_prod;
    logic        range_err;
    logic [7:0]  n_hund;
    logic [7:0]  n_tens;
    logic [7:0]  n_ones;
    logic [7:0]  n_tenths;

    // Flow control: result register moves when empty or taken
    assign out_move = !r_out_valid || !i_stall;
    assign s1_move  = !r_s1_valid || out_move;
    assign o_stall  = !s1_move;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_move) begin
            r_s1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move && i_valid) begin
            r_s1_raw <= i_temp_raw;
        end
    end

    // Magnitude and whole / fractional split
    always_comb begin
        neg       = r_s1_raw[15];
        mag       = neg ? (16'd0 - r_s1_raw) : r_s1_raw;
        whole     = mag[15:4];
        frac      = mag[3:0];
        whole10   = whole[9:0];
        range_err = (whole > t2ss_pkg::MAX_WHOLE);

        // hundreds by reciprocal, remainder, then tens and ones
        hund_prod = {6'd0, whole10} * t2ss_pkg::RECIP_100;
        hund      = hund_prod[15:12];
        rem_full  = whole10 - ({6'd0, hund} * 10'd100);
        rem       = rem_full[6:0];
        tens_prod = {8'd0, rem} * t2ss_pkg::RECIP_10;
        tens      = tens_prod[14:11];
        ones_full = rem - ({3'd0, tens} * 7'd10);
        frac_prod = {4'd0, frac} * 8'd10;
    end

    // Segment codes with blanking and minus placement
    always_comb begin
        n_hund   = (hund != 4'd0) ? t2ss_pkg::seg_code(hund) : t2ss_pkg::SEG_BLANK;
        n_tens   = (tens != 4'd0 || hund != 4'd0) ? t2ss_pkg::seg_code(tens)
                                                  : t2ss_pkg::SEG_BLANK;
        n_ones   = t2ss_pkg::seg_code(ones_full[3:0]) & t2ss_pkg::SEG_DOT_MASK;
        n_tenths = t2ss_pkg::seg_code(frac_prod[7:4]);
        if (neg) begin
            if (n_tens == t2ss_pkg::SEG_BLANK) begin
                n_tens = t2ss_pkg::SEG_MINUS;
            end else begin
                n_hund = t2ss_pkg::SEG_MINUS;
            end
        end
        if (range_err) begin
            n_hund   = t2ss_pkg::SEG_BLANK;
            n_tens   = t2ss_pkg::SEG_BLANK;
            n_ones   = t2ss_pkg::SEG_BLANK;
            n_tenths = t2ss_pkg::SEG_BLANK;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_move) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_move && r_s1_valid) begin
            r_hund   <= n_hund;
            r_tens   <= n_tens;
            r_ones   <= n_ones;
            r_tenths <= n_tenths;
            r_err    <= range_err;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_digit_hundreds = r_hund;
    assign o_digit_tens     = r_tens;
    assign o_digit_ones     = r_ones;
    assign o_digit_tenths   = r_tenths;
    assign o_range_error    = r_err;

    // Out-of-range results are fully blank
    a_err_blank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_range_error) |->
            (o_digit_hundreds == t2ss_pkg::SEG_BLANK && o_digit_tens == t2ss_pkg::SEG_BLANK
             && o_digit_ones == t2ss_pkg::SEG_BLANK
             && o_digit_tenths == t2ss_pkg::SEG_BLANK))
        else $error("range error without blank digits");

    // In-range results always light the ones dot
    a_dot_lit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_range_error) |-> !o_digit_ones[0])
        else $error("ones digit dot not lit");

    // Input stalls only when both stages hold data and output is stalled
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_s1_valid && r_out_valid && i_stall))
        else $error("input stalled with room in pipeline");

    // An accepted transaction lands in the input register
    a_accept_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> r_s1_valid)
        else $error("accepted transaction lost");

    // A held input stage with an open result stage moves forward
    a_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && out_move) |=> r_out_valid)
        else $error("transaction dropped between stages");

endmodule
